>>> hw/rtl/wgbs_pkg.sv
`default_nettype none

package wgbs_pkg;

	// field and register widths
	localparam int TW_W    = 11;
	localparam int POS_W   = 24;
	localparam int IDX_W   = 11;
	localparam int FIELD_W = 16;
	localparam int NFIELD  = 3;

	// position fraction bits and the integer part of a shifted position
	localparam int POS_FRAC = 8;
	localparam int POS_HI_W = POS_W + 1 - POS_FRAC;

	// weight fraction bits
	localparam int WF = 16;

	localparam logic [TW_W-1:0] TW_RESET = TW_W'(100);

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// field slots inside one grid entry
	localparam int F_NZ     = 0;
	localparam int F_NX     = 1;
	localparam int F_HEIGHT = 2;

	// result queue
	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = 6;

	typedef logic [NFIELD-1:0][FIELD_W-1:0] sample_t;

	typedef struct packed {
		logic              valid;
		logic              is_load;
		logic [IDX_W-1:0]  idx;
		sample_t           data;
	} item_t;

endpackage

`default_nettype wire

>>> hw/rtl/wrapped_grid_bilinear_sampler.sv
`default_nettype none

// Wrapped-grid bilinear sampler. Holds a (GRID_SEGMENTS+1)^2 grid of
// height / normal-x / normal-z samples and answers position queries with a
// bilinear blend of the four neighboring entries, the position first shifted
// by half a tile, wrapped into the tile (width set by cfg_data, 0 acts as 1)
// and scaled to grid units with x mirrored. One item (query or load) is taken
// every clock while full is low. A query passes through the coordinate
// pipeline, the corner lookup and blend, and the result queue, all registered.
// Per axis a restoring divider for the wrap and one for the scaling run in
// series, one bit per stage, and make up most of the pipeline; the corner
// lookup and blend add five stages and the result queue two. Loads flow
// through the same pipeline so they take effect in order with queries; a
// load makes no result. Up to 64 queries may be outstanding; full rises
// when that many have not been popped. Reading a grid entry never loaded
// gives an undefined result.
module wrapped_grid_bilinear_sampler #(
	parameter int GRID_SEGMENTS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               opcode,
	input  wire logic signed [wgbs_pkg::POS_W-1:0]  pos_x,
	input  wire logic signed [wgbs_pkg::POS_W-1:0]  pos_z,
	input  wire logic [wgbs_pkg::IDX_W-1:0]         entry_index,
	input  wire logic signed [wgbs_pkg::FIELD_W-1:0] entry_height,
	input  wire logic signed [wgbs_pkg::FIELD_W-1:0] entry_normal_x,
	input  wire logic signed [wgbs_pkg::FIELD_W-1:0] entry_normal_z,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [wgbs_pkg::FIELD_W-1:0]     sample_height,
	output logic signed [wgbs_pkg::FIELD_W-1:0]     sample_normal_x,
	output logic signed [wgbs_pkg::FIELD_W-1:0]     sample_normal_z,
	input  wire logic                               cfg_we,
	input  wire logic [wgbs_pkg::TW_W-1:0]          cfg_data
);
	import wgbs_pkg::*;

	localparam int SIDE = GRID_SEGMENTS + 1;
	localparam int XW   = $clog2(SIDE + 1) + WF;
	// coordinate pipeline depth: abs stage, mod divider, fold, scale, divider
	localparam int LC   = POS_HI_W + 2 + 1 + XW;

	logic [TW_W-1:0]    tw_q;
	logic [FIFO_AW:0]   credit_q;
	logic               accept;
	logic               q_take;
	logic               q_done;
	item_t              item_in;
	item_t              side_q [LC];
	logic [XW-1:0]      ux, uz;
	logic               res_push;
	sample_t            res_data;
	sample_t            head;

	assign accept = push && !full;
	assign q_take = accept && (opcode == OP_QUERY);
	assign q_done = pop && !empty;
	assign full   = (credit_q == (FIFO_AW+1)'(FIFO_DEPTH));

	// tile width, zero replaced by one at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= TW_RESET;
		end else if (cfg_we) begin
			tw_q <= (cfg_data == '0) ? TW_W'(1) : cfg_data;
		end
	end

	// count queries accepted but not yet popped so the queue never overflows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + (FIFO_AW+1)'(q_take) - (FIFO_AW+1)'(q_done);
		end
	end

	assign item_in.valid   = accept;
	assign item_in.is_load = (opcode == OP_LOAD);
	assign item_in.idx     = entry_index;
	assign item_in.data    = {entry_height, entry_normal_x, entry_normal_z};

	// carry the item beside the coordinate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LC; i++) begin
				side_q[i] <= '0;
			end
		end else begin
			side_q[0] <= item_in;
			for (int i = 1; i < LC; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	wgbs_coord #(.SIDE(SIDE), .XW(XW)) u_coord_x (
		.clk (clk),
		.tw  (tw_q),
		.pos (pos_x),
		.u   (ux)
	);

	wgbs_coord #(.SIDE(SIDE), .XW(XW)) u_coord_z (
		.clk (clk),
		.tw  (tw_q),
		.pos (pos_z),
		.u   (uz)
	);

	wgbs_back #(.SIDE(SIDE), .XW(XW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ux       (ux),
		.uz       (uz),
		.item     (side_q[LC-1]),
		.res_push (res_push),
		.res_data (res_data)
	);

	wgbs_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.pop     (pop),
		.empty   (empty),
		.rd_data (head)
	);

	assign sample_height   = head[F_HEIGHT];
	assign sample_normal_x = head[F_NX];
	assign sample_normal_z = head[F_NZ];

endmodule

`default_nettype wire

>>> hw/rtl/wgbs_div.sv
`default_nettype none

// Restoring divider by a small divisor, one quotient bit per stage.
// The top TW_W bits of num must be below divisor.
module wgbs_div #(
	parameter int QB = 17
) (
	input  wire logic                             clk,
	input  wire logic [wgbs_pkg::TW_W-1:0]        divisor,
	input  wire logic [QB+wgbs_pkg::TW_W-1:0]     num,
	output logic      [QB-1:0]                    quo,
	output logic      [wgbs_pkg::TW_W-1:0]        rem
);
	import wgbs_pkg::*;

	logic [TW_W-1:0] r_s [QB];
	logic [QB-1:0]   l_s [QB];
	logic [QB-1:0]   q_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [TW_W-1:0] r_in;
		logic [QB-1:0]   l_in;
		logic [QB-1:0]   q_in;
		logic [TW_W:0]   t;

		if (k == 0) begin : g_first
			assign r_in = num[QB+TW_W-1:QB];
			assign l_in = num[QB-1:0];
			assign q_in = '0;
		end else begin : g_next
			assign r_in = r_s[k-1];
			assign l_in = l_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign t = {r_in, l_in[QB-1]};

		always_ff @(posedge clk) begin
			if (t >= {1'b0, divisor}) begin
				r_s[k] <= TW_W'(t - {1'b0, divisor});
				q_s[k] <= {q_in[QB-2:0], 1'b1};
			end else begin
				r_s[k] <= TW_W'(t);
				q_s[k] <= {q_in[QB-2:0], 1'b0};
			end
			l_s[k] <= {l_in[QB-2:0], 1'b0};
		end
	end

	assign quo = q_s[QB-1];
	assign rem = r_s[QB-1];

endmodule

`default_nettype wire

>>> hw/rtl/wgbs_coord.sv
`default_nettype none

// Wrap one position axis into the tile and scale it to grid units.
module wgbs_coord #(
	parameter int SIDE = 33,
	parameter int XW   = 22
) (
	input  wire logic                              clk,
	input  wire logic        [wgbs_pkg::TW_W-1:0]  tw,
	input  wire logic signed [wgbs_pkg::POS_W-1:0] pos,
	output logic             [XW-1:0]              u
);
	import wgbs_pkg::*;

	localparam int PW = POS_W + 1;
	localparam int RW = TW_W + POS_FRAC;
	localparam int NW = XW + TW_W;

	logic signed [PW-1:0]       p;
	logic signed [POS_HI_W-1:0] p_hi;
	logic [POS_HI_W-1:0]        mag_s1;
	logic                       neg_s1;
	logic [POS_FRAC-1:0]        low_s1;
	logic [POS_FRAC:0]          side_q [POS_HI_W];
	logic [POS_HI_W-1:0]        quo1;
	logic [TW_W-1:0]            rem1;
	logic [TW_W-1:0]            rem2;
	logic [TW_W-1:0]            m;
	logic [RW-1:0]              r_s2;
	logic [NW-1:0]              n_s3;
	logic [NW-1:0]              num2;
	logic                       unused_div;

	// shift by half a tile
	assign p    = $signed({pos[POS_W-1], pos}) + $signed(PW'({tw, 7'b0}));
	assign p_hi = p[PW-1:POS_FRAC];

	always_ff @(posedge clk) begin
		neg_s1 <= p_hi[POS_HI_W-1];
		mag_s1 <= p_hi[POS_HI_W-1] ? POS_HI_W'(-p_hi) : POS_HI_W'(p_hi);
		low_s1 <= p[POS_FRAC-1:0];
	end

	wgbs_div #(.QB(POS_HI_W)) u_mod (
		.clk     (clk),
		.divisor (tw),
		.num     ({TW_W'(0), mag_s1}),
		.quo     (quo1),
		.rem     (rem1)
	);

	// hold sign and fraction alongside the divider
	always_ff @(posedge clk) begin
		side_q[0] <= {neg_s1, low_s1};
		for (int i = 1; i < POS_HI_W; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// floor modulo: fold a negative remainder back into the tile
	always_comb begin
		m = rem1;
		if (side_q[POS_HI_W-1][POS_FRAC] && rem1 != '0) begin
			m = tw - rem1;
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= {m, side_q[POS_HI_W-1][POS_FRAC-1:0]};
		n_s3 <= NW'(r_s2) * NW'(SIDE);
	end

	assign num2 = {n_s3[NW-POS_FRAC-1:0], POS_FRAC'(0)};

	wgbs_div #(.QB(XW)) u_scale (
		.clk     (clk),
		.divisor (tw),
		.num     (num2),
		.quo     (u),
		.rem     (rem2)
	);

	// the wrap quotient and the scaling remainder carry no information
	assign unused_div = ^{quo1, rem2};

endmodule

`default_nettype wire

>>> hw/rtl/wgbs_back.sv
`default_nettype none

// Corner lookup in the replicated grid and the bilinear blend.
module wgbs_back #(
	parameter int SIDE = 33,
	parameter int XW   = 22
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [XW-1:0]           ux,
	input  wire logic [XW-1:0]           uz,
	input  wire wgbs_pkg::item_t         item,
	output logic                         res_push,
	output wgbs_pkg::sample_t            res_data
);
	import wgbs_pkg::*;

	localparam int IW    = XW - WF;
	localparam int DEPTH = SIDE * SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int ROW_W = FIELD_W + WF + 3;
	localparam int SUM_W = ROW_W + WF + 2;
	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << 31;
	localparam logic [WF:0] W_ONE = (WF+1)'(1) << WF;

	logic [XW-1:0] xf;
	logic [IW-1:0] x0r, x1r, z0r, z1r;
	logic [WF-1:0] wx, wz;

	logic [IW-1:0] x0_s1, x1_s1, z0_s1, z1_s1;
	logic [WF-1:0] wx_s1, wz_s1;
	item_t         item_s1, item_s2, item_s3, item_s4, item_s5;

	logic [AW-1:0] a_s2 [4];
	logic [WF-1:0] wx_s2, wz_s2, wx_s3, wz_s3, wz_s4;
	logic          we_s2;
	logic [AW-1:0] wa_s2;
	sample_t       rd_s3 [4];

	// mirror x; z is used as is
	assign xf  = (XW'(SIDE) << WF) - ux;
	assign x0r = xf[XW-1:WF];
	assign wx  = xf[WF-1:0];
	assign z0r = uz[XW-1:WF];
	assign wz  = uz[WF-1:0];
	assign x1r = x0r + IW'(wx != '0);
	assign z1r = z0r + IW'(wz != '0);

	always_ff @(posedge clk) begin
		x0_s1 <= (int'(x0r) >= SIDE) ? '0 : x0r;
		x1_s1 <= (int'(x1r) >= SIDE) ? '0 : x1r;
		z0_s1 <= (int'(z0r) >= SIDE) ? '0 : z0r;
		z1_s1 <= (int'(z1r) >= SIDE) ? '0 : z1r;
		wx_s1 <= wx;
		wz_s1 <= wz;
	end

	// corner order: 0 = (x0,z0), 1 = (x1,z0), 2 = (x0,z1), 3 = (x1,z1)
	always_ff @(posedge clk) begin
		a_s2[0] <= AW'(SIDE * int'(z0_s1) + int'(x0_s1));
		a_s2[1] <= AW'(SIDE * int'(z0_s1) + int'(x1_s1));
		a_s2[2] <= AW'(SIDE * int'(z1_s1) + int'(x0_s1));
		a_s2[3] <= AW'(SIDE * int'(z1_s1) + int'(x1_s1));
		wx_s2   <= wx_s1;
		wz_s2   <= wz_s1;
		wa_s2   <= AW'(item_s1.idx);
		wx_s3   <= wx_s2;
		wz_s3   <= wz_s2;
		wz_s4   <= wz_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
			item_s3 <= '0;
			item_s4 <= '0;
			item_s5 <= '0;
			we_s2   <= 1'b0;
		end else begin
			item_s1 <= item;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			item_s5 <= item_s4;
			we_s2   <= item_s1.valid && item_s1.is_load && (int'(item_s1.idx) < DEPTH);
		end
	end

	// one grid copy per corner, all written alike
	for (genvar c = 0; c < 4; c++) begin : g_copy
		sample_t mem [DEPTH];

		always_ff @(posedge clk) begin
			if (we_s2) begin
				mem[wa_s2] <= item_s2.data;
			end
			rd_s3[c] <= mem[a_s2[c]];
		end
	end

	logic [WF:0] ax3, wx3, az4, wz4;
	assign ax3 = W_ONE - {1'b0, wx_s3};
	assign wx3 = {1'b0, wx_s3};
	assign az4 = W_ONE - {1'b0, wz_s4};
	assign wz4 = {1'b0, wz_s4};

	for (genvar j = 0; j < NFIELD; j++) begin : g_field
		logic signed [ROW_W-1:0] r0_s4, r1_s4;
		logic signed [SUM_W-1:0] s_s5;
		logic        [SUM_W-1:0] rnd;

		// blend along x, then along z
		always_ff @(posedge clk) begin
			r0_s4 <= $signed(rd_s3[0][j]) * $signed({1'b0, ax3})
			       + $signed(rd_s3[1][j]) * $signed({1'b0, wx3});
			r1_s4 <= $signed(rd_s3[2][j]) * $signed({1'b0, ax3})
			       + $signed(rd_s3[3][j]) * $signed({1'b0, wx3});
			s_s5  <= r0_s4 * $signed({1'b0, az4}) + r1_s4 * $signed({1'b0, wz4});
		end

		// round half up and drop the 32 weight fraction bits
		assign rnd         = $unsigned(s_s5) + RND_HALF;
		assign res_data[j] = rnd[47:32];
	end

	assign res_push = item_s5.valid && !item_s5.is_load;

endmodule

`default_nettype wire

>>> hw/rtl/wgbs_fifo.sv
`default_nettype none

// Result queue: memory plus a registered head.
module wgbs_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire wgbs_pkg::sample_t  wr_data,
	input  wire logic               pop,
	output logic                    empty,
	output wgbs_pkg::sample_t       rd_data
);
	import wgbs_pkg::*;

	sample_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wptr_q, rptr_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 head_vld_q;
	logic                 load_head;

	assign load_head = (cnt_q != '0) && (!head_vld_q || pop);
	assign empty     = !head_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_data;
		end
		if (load_head) begin
			rd_data <= mem[rptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			cnt_q      <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (load_head) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(load_head);
			if (load_head) begin
				head_vld_q <= 1'b1;
			end else if (pop) begin
				head_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
